### hw/rtl/bpn_pkg.sv
// bpn_pkg: shared types, constants and helpers of the block peak normaliser.
// Used by bpn_store, bpn_div and block_peak_normalizer_top; no dependencies.
package bpn_pkg;

   // Sample format, Q1.23 signed
   localparam int SAMPLE_W           = 24;
   localparam int BLOCK_CAPACITY_DEF = 64;

   // Product of magnitude and target, and divider steps
   localparam int PROD_W    = 2 * SAMPLE_W;
   localparam int DIV_STEPS = SAMPLE_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   localparam logic [SAMPLE_W-1:0] TARGET_RESET = 24'h800000;
   localparam logic [SAMPLE_W-1:0] SAT_POS      = 24'h7FFFFF;
   localparam logic [SAMPLE_W-1:0] SAT_NEG      = 24'h800000;
   localparam logic [SAMPLE_W-1:0] NEG_LIMIT    = 24'h800000;

   // Sequencer states, one-hot
   typedef enum logic [6:0] {
      S_LOAD   = 7'b0000001,
      S_READ   = 7'b0000010,
      S_MAG    = 7'b0000100,
      S_MULT   = 7'b0001000,
      S_DSTART = 7'b0010000,
      S_DWAIT  = 7'b0100000,
      S_EMIT   = 7'b1000000
   } state_type;

   // Sequencer to divider
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   // Divider to sequencer
   typedef struct packed {
      logic busy;
      logic done;
      logic ovf;
   } div_stat_type;

   // Absolute value of a signed sample; the most negative code maps to 2^23
   function automatic logic [SAMPLE_W-1:0] magnitude(input logic [SAMPLE_W-1:0] s);
      magnitude = s[SAMPLE_W-1] ? (~s + SAMPLE_W'(1)) : s;
   endfunction

endpackage

### hw/rtl/bpn_store.sv
// bpn_store: block sample memory, one write port and one registered read port.
// Depends on bpn_pkg for the sample width.
module bpn_store #(
   parameter int BLOCK_CAPACITY = bpn_pkg::BLOCK_CAPACITY_DEF,
   parameter int AW             = 6
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [bpn_pkg::SAMPLE_W-1:0]  wr_data,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_addr,
   output logic [bpn_pkg::SAMPLE_W-1:0]  rd_data
);

   logic [bpn_pkg::SAMPLE_W-1:0] sample_store [BLOCK_CAPACITY];
   logic [bpn_pkg::SAMPLE_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         sample_store[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= sample_store[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/bpn_div.sv
// bpn_div: restoring divider, one quotient bit per cycle, 24 steps.
// Flags a quotient of 2^24 or more at once. Depends on bpn_pkg.
module bpn_div (
   input  logic                          clock,
   input  logic                          reset,
   input  bpn_pkg::div_ctrl_type         ctrl,
   input  logic [bpn_pkg::PROD_W-1:0]    dividend,
   input  logic [bpn_pkg::SAMPLE_W-1:0]  divisor,
   output bpn_pkg::div_stat_type         stat,
   output logic [bpn_pkg::SAMPLE_W-1:0]  quotient
);

   localparam int W = bpn_pkg::SAMPLE_W;

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic                            ovf_ff, ovf_in;
   logic [bpn_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [W-1:0]                    rem_ff, rem_in;
   logic [W-1:0]                    quo_ff, quo_in;
   logic [W-1:0]                    dsr_ff, dsr_in;
   logic [W:0]                      shifted;
   logic [W+1:0]                    trial;

   // Partial remainder shifted by one dividend bit, and trial subtraction
   assign shifted = {rem_ff, quo_ff[W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (ctrl.start) begin
         dsr_in = divisor;
         rem_in = dividend[bpn_pkg::PROD_W-1:W];
         quo_in = dividend[W-1:0];
         cnt_in = bpn_pkg::DIV_CNT_W'(bpn_pkg::DIV_STEPS);
         // high half not below the divisor: quotient does not fit
         if (dividend[bpn_pkg::PROD_W-1:W] >= divisor) begin
            ovf_in  = 1'b1;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            ovf_in  = 1'b0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (!trial[W+1]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - bpn_pkg::DIV_CNT_W'(1);
         if (cnt_ff == bpn_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         ovf_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         ovf_ff  <= ovf_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.ovf  = ovf_ff;
   assign quotient  = quo_ff;

endmodule

### hw/rtl/block_peak_normalizer_top.sv
// block_peak_normalizer_top: loads a block of samples one per cycle, then scales each
// by the programmed peak goal / peak through one multiplier and one shared serial divider.
// Drain: each stored sample passes through read, magnitude, multiply, divider start, divider wait
// and emit; a silent block goes from magnitude straight to emit, and a quotient of 2^24 or more ends the wait early.
// Throughput: one sample per cycle while loading; input stalls during the drain.
// Reset (synchronous, active high) clears the block state and sets the peak goal to 1.0.
module block_peak_normalizer_top #(
   parameter int BLOCK_CAPACITY = bpn_pkg::BLOCK_CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [bpn_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic                                req_last_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [bpn_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                                rsp_last_out,
   output logic                                rsp_overflowed,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bpn_pkg::SAMPLE_W-1:0]        csr_peak_goal
);

   localparam int W  = bpn_pkg::SAMPLE_W;
   localparam int CW = $clog2(BLOCK_CAPACITY + 1);
   localparam int AW = (BLOCK_CAPACITY > 1) ? $clog2(BLOCK_CAPACITY) : 1;

   bpn_pkg::state_type          state_ff, state_in;
   logic [W-1:0]                target_ff;
   logic [CW-1:0]               count_ff, count_in;
   logic [W-1:0]                peak_ff, peak_in;
   logic                        drop_ff, drop_in;
   logic [AW-1:0]               idx_ff, idx_in;
   logic [W-1:0]                mag_ff, mag_in;
   logic                        neg_ff, neg_in;
   logic [bpn_pkg::PROD_W-1:0]  prod_ff;
   logic [W-1:0]                res_ff, res_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]                rsp_sample_ff;
   logic                        rsp_last_ff, rsp_ovf_ff;

   logic                        req_xfer;
   logic                        room;
   logic [W-1:0]                in_mag;
   logic                        wr_en, rd_en;
   logic [W-1:0]                rd_data;
   logic                        out_free, out_load;
   logic                        is_last;
   logic [W-1:0]                sat_val;
   bpn_pkg::div_ctrl_type       div_ctrl;
   bpn_pkg::div_stat_type       div_stat;
   logic [W-1:0]                div_q;

   // Handshakes
   assign req_stall = (state_ff != bpn_pkg::S_LOAD);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign room      = (count_ff < CW'(BLOCK_CAPACITY));
   assign in_mag    = bpn_pkg::magnitude(req_sample_in);
   assign wr_en     = req_xfer && room;
   assign rd_en     = (state_ff == bpn_pkg::S_READ);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign out_load  = (state_ff == bpn_pkg::S_EMIT) && out_free;
   assign is_last   = ((CW'(idx_ff) + CW'(1)) == count_ff);
   assign div_ctrl.start = (state_ff == bpn_pkg::S_DSTART);

   bpn_store #(
      .BLOCK_CAPACITY (BLOCK_CAPACITY),
      .AW             (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_sample_in),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   bpn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (prod_ff),
      .divisor  (peak_ff),
      .stat     (div_stat),
      .quotient (div_q)
   );

   // Saturate the quotient and restore the sign
   always_comb begin
      if (neg_ff) begin
         if (div_stat.ovf || (div_q > bpn_pkg::NEG_LIMIT)) begin
            sat_val = bpn_pkg::SAT_NEG;
         end else begin
            sat_val = ~div_q + W'(1);
         end
      end else begin
         if (div_stat.ovf || (div_q > bpn_pkg::SAT_POS)) begin
            sat_val = bpn_pkg::SAT_POS;
         end else begin
            sat_val = div_q;
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      peak_in      = peak_ff;
      drop_in      = drop_ff;
      idx_in       = idx_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         bpn_pkg::S_LOAD: begin
            if (req_xfer) begin
               if (room) begin
                  count_in = count_ff + CW'(1);
                  if (in_mag > peak_ff) begin
                     peak_in = in_mag;
                  end
               end else begin
                  drop_in = 1'b1;
               end
               if (req_last_in) begin
                  idx_in   = '0;
                  state_in = bpn_pkg::S_READ;
               end
            end
         end
         bpn_pkg::S_READ: begin
            state_in = bpn_pkg::S_MAG;
         end
         bpn_pkg::S_MAG: begin
            mag_in = bpn_pkg::magnitude(rd_data);
            neg_in = rd_data[W-1];
            // silent block passes through unchanged
            if (peak_ff == '0) begin
               res_in   = rd_data;
               state_in = bpn_pkg::S_EMIT;
            end else begin
               state_in = bpn_pkg::S_MULT;
            end
         end
         bpn_pkg::S_MULT: begin
            state_in = bpn_pkg::S_DSTART;
         end
         bpn_pkg::S_DSTART: begin
            state_in = bpn_pkg::S_DWAIT;
         end
         bpn_pkg::S_DWAIT: begin
            if (div_stat.done) begin
               res_in   = sat_val;
               state_in = bpn_pkg::S_EMIT;
            end
         end
         bpn_pkg::S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (is_last) begin
                  count_in = '0;
                  peak_in  = '0;
                  drop_in  = 1'b0;
                  state_in = bpn_pkg::S_LOAD;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = bpn_pkg::S_READ;
               end
            end
         end
         default: begin
            state_in = bpn_pkg::S_LOAD;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpn_pkg::S_LOAD;
         count_ff     <= '0;
         peak_ff      <= '0;
         drop_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         target_ff    <= bpn_pkg::TARGET_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         peak_ff      <= peak_in;
         drop_ff      <= drop_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            target_ff <= csr_peak_goal;
         end
      end
   end

   // Datapath registers; the product is registered ahead of the divider
   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
      if (state_ff == bpn_pkg::S_MULT) begin
         prod_ff <= mag_ff * target_ff;
      end
      if (out_load) begin
         rsp_sample_ff <= res_ff;
         rsp_last_ff   <= is_last;
         rsp_ovf_ff    <= drop_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_last_out   = rsp_last_ff;
   assign rsp_overflowed = rsp_ovf_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(BLOCK_CAPACITY))
      else $error("stored count above capacity");

   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      peak_ff <= bpn_pkg::NEG_LIMIT)
      else $error("running peak above full scale");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != bpn_pkg::S_LOAD) |-> (count_ff != '0))
      else $error("draining an empty block");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == bpn_pkg::S_DWAIT))
      else $error("divider finished outside its wait state");

   a_out_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(rsp_sample_ff))
      else $error("held result overwritten");

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking testbench for block_peak_normalizer_top.
// Depends on bpn_pkg and the top level; holds its own block normaliser predictor.

// One normalised sample as it leaves the block
typedef struct packed {
   logic [23:0] sample;
   logic        last;
   logic        ovf;
} norm_out_type;

// Predicts the normalised output of each block and checks what comes out
class norm_block_checker;
   localparam int CAP = bpn_pkg::BLOCK_CAPACITY_DEF;

   logic [23:0]  sample_buf [CAP];
   int           fill;
   logic [23:0]  peak;
   logic         dropped;
   logic [23:0]  target;
   norm_out_type scaled_due [$];
   int           mismatches;

   function new();
      fill       = 0;
      peak       = '0;
      dropped    = 1'b0;
      target     = bpn_pkg::TARGET_RESET;
      mismatches = 0;
   endfunction

   function int pending();
      return scaled_due.size();
   endfunction

   // sample * target / peak, truncated toward zero, saturated to 24-bit signed
   function logic [23:0] scale_to_target(logic [23:0] raw);
      logic [23:0] mag;
      logic [63:0] q;
      logic [63:0] neg;
      if (peak == '0) return raw;
      mag = raw[23] ? (~raw + 24'd1) : raw;
      q   = (64'(mag) * 64'(target)) / 64'(peak);
      if (raw[23]) begin
         if (q > 64'(bpn_pkg::SAT_NEG)) q = 64'(bpn_pkg::SAT_NEG);
         neg = ~q + 64'd1;
         return neg[23:0];
      end
      if (q > 64'(bpn_pkg::SAT_POS)) q = 64'(bpn_pkg::SAT_POS);
      return q[23:0];
   endfunction

   // Note one accepted input transfer; a last sample releases the whole block
   function void accept_sample(logic [23:0] raw, logic last);
      logic [23:0]  mag;
      norm_out_type e;
      if (fill < CAP) begin
         sample_buf[fill] = raw;
         fill++;
         mag = raw[23] ? (~raw + 24'd1) : raw;
         if (mag > peak) peak = mag;
      end else begin
         dropped = 1'b1;
      end
      if (!last) return;
      for (int i = 0; i < fill; i++) begin
         e.sample = scale_to_target(sample_buf[i]);
         e.last   = (i == fill - 1);
         e.ovf    = dropped;
         scaled_due.push_back(e);
      end
      fill    = 0;
      peak    = '0;
      dropped = 1'b0;
   endfunction

   task report_mismatch(string what);
      if (mismatches < 100) $display("MISMATCH: %s", what);
      mismatches++;
   endtask

   // Compare one result transfer against the oldest expectation
   task check_output(logic [23:0] sample, logic last, logic ovf);
      norm_out_type e;
      if (scaled_due.size() == 0) begin
         report_mismatch($sformatf("unexpected result sample %h last %b ovf %b",
                                   sample, last, ovf));
         return;
      end
      e = scaled_due.pop_front();
      if (sample !== e.sample || last !== e.last || ovf !== e.ovf)
         report_mismatch($sformatf("got sample %h last %b ovf %b, expected %h %b %b",
                                   sample, last, ovf, e.sample, e.last, e.ovf));
   endtask
endclass

module tb_top;
   localparam int CAP          = bpn_pkg::BLOCK_CAPACITY_DEF;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 64;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic signed [bpn_pkg::SAMPLE_W-1:0] req_sample_in;
   logic                                req_last_in;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [bpn_pkg::SAMPLE_W-1:0] rsp_sample_out;
   logic                                rsp_last_out;
   logic                                rsp_overflowed;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [bpn_pkg::SAMPLE_W-1:0]        csr_peak_goal;

   norm_block_checker checker_h;
   int                req_idle_pct;
   int                rsp_idle_pct;
   int                stall_left = 0;
   int                cycle_count = 0;

   block_peak_normalizer_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample_in   (req_sample_in),
      .req_last_in     (req_last_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_last_out    (rsp_last_out),
      .rsp_overflowed  (rsp_overflowed),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_peak_goal   (csr_peak_goal)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Transfer monitors: inputs, register writes and results, all at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) checker_h.target = csr_peak_goal;
         if (req_valid && !req_stall) checker_h.accept_sample(req_sample_in, req_last_in);
         if (rsp_valid && !rsp_stall)
            checker_h.check_output(rsp_sample_out, rsp_last_out, rsp_overflowed);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL block_peak_normalizer_top");
         $finish;
      end
   end

   // Receiver back-pressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0)
         stall_left--;
      else if (rsp_idle_pct != 0 && $urandom_range(99) < rsp_idle_pct)
         stall_left = $urandom_range(16, 1);
      rsp_stall <= (stall_left > 0);
   end

   // One input transfer; entered and left just after a falling edge
   task send_item(logic [23:0] sample, logic last);
      if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(16, 1)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= sample;
      req_last_in   <= last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Let every expected result arrive, then give the block time to settle
   task wait_idle();
      req_valid <= 1'b0;
      while (checker_h.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task write_target(logic [23:0] value);
      csr_valid     <= 1'b1;
      csr_peak_goal <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Sample flavours: full range, quiet, silence, extreme codes
   function logic [23:0] pick_sample(int kind, int idx);
      int v;
      if (idx >= CAP) return 24'($urandom());
      case (kind)
         1: begin
            v = int'($urandom_range(4094)) - 2047;
            return v[23:0];
         end
         2: return 24'd0;
         3: begin
            case ($urandom_range(7))
               0: return 24'h800000;
               1: return 24'h7FFFFF;
               2: return 24'h800001;
               3: return 24'hFFFFFF;
               4: return 24'h000001;
               default: return 24'($urandom());
            endcase
         end
         default: return 24'($urandom());
      endcase
   endfunction

   task send_block(int len);
      int kind;
      int r;
      r = $urandom_range(99);
      kind = (r < 45) ? 0 : (r < 70) ? 1 : (r < 80) ? 2 : 3;
      for (int i = 0; i < len; i++) send_item(pick_sample(kind, i), i == len - 1);
   endtask

   // A run of blocks under one target setting
   task run_phase(logic [23:0] target, int budget, int big_len, bit quiet);
      int sent;
      int len;
      wait_idle();
      write_target(target);
      req_idle_pct = quiet ? 0 : 20 * $urandom_range(2);
      rsp_idle_pct = quiet ? 0 : 20 * $urandom_range(2);
      if (big_len > 0) send_block(big_len);
      sent = 0;
      while (sent < budget) begin
         len = ($urandom_range(99) < 80) ? $urandom_range(6, 1) : $urandom_range(24, 7);
         send_block(len);
         sent += len;
      end
   endtask

   initial begin
      checker_h       = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_sample_in   = '0;
      req_last_in     = 1'b0;
      csr_valid       = 1'b0;
      csr_peak_goal   = '0;
      req_idle_pct    = 25;
      rsp_idle_pct    = 25;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset target (unity): extreme codes, silence, lone most negative code
      send_item(24'h7FFFFF, 1'b0);
      send_item(24'h800000, 1'b0);
      send_item(24'h000000, 1'b0);
      send_item(24'h000001, 1'b0);
      send_item(24'hFFFFFF, 1'b1);
      send_item(24'h000000, 1'b1);
      send_item(24'h000000, 1'b0);
      send_item(24'h000000, 1'b0);
      send_item(24'h000000, 1'b1);
      send_item(24'h800000, 1'b1);
      // Low peak: gain of two, positive side saturates
      send_item(24'h400000, 1'b0);
      send_item(24'hF00000, 1'b1);

      // Zero target: a non-silent block comes out all zero
      wait_idle();
      write_target(24'd0);
      send_item(24'h000005, 1'b0);
      send_item(24'hFFFFF9, 1'b1);

      // Largest target: gain above one, both sides saturate
      wait_idle();
      write_target(24'hFFFFFF);
      send_item(24'h000064, 1'b0);
      send_item(24'hFFFF9C, 1'b0);
      send_item(24'h000003, 1'b1);

      // Tiny target: truncation toward zero
      wait_idle();
      write_target(24'd1);
      send_item(24'h7FFFFF, 1'b0);
      send_item(24'h800000, 1'b1);

      // Random blocks; a full block and one whose last sample is dropped
      run_phase(24'($urandom_range(8388608)), 16, 0, 1'b0);
      run_phase(bpn_pkg::TARGET_RESET, 16, CAP, 1'b0);
      run_phase(24'd0, 16, 0, 1'b0);
      run_phase(24'($urandom_range(24'hFFFFFF, 24'h800001)), 16, CAP + 1, 1'b0);
      run_phase(24'($urandom_range(4096, 1)), 16, 0, 1'b0);
      // Closing stretch runs without idling on either side
      run_phase(bpn_pkg::TARGET_RESET, 16, 0, 1'b1);

      wait_idle();
      if (checker_h.mismatches == 0 && checker_h.pending() == 0)
         $display("PASS block_peak_normalizer_top");
      else
         $display("FAIL block_peak_normalizer_top");
      $finish;
   end
endmodule
